// ===== rtl/core/kcpt_pkg.sv =====
// Shared constants for the constant-acceleration position tracker.
// Opcodes, register indexes and register reset values; no dependencies.
`timescale 1ns / 1ps

package kcpt_pkg;

  localparam int DEF_FRAC_BITS = 40;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_POS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_VEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_ACC    = 3'd5;

  localparam logic [31:0] RST_PROC_NOISE = 32'd419430400;
  localparam logic [31:0] RST_MEAS_NOISE = 32'd6711;
  localparam logic [19:0] RST_FALLBACK   = 20'd16667;
  localparam logic [31:0] RST_VAR_POS    = 32'd16777;
  localparam logic [31:0] RST_VAR_VEL    = 32'd1677722;
  localparam logic [31:0] RST_VAR_ACC    = 32'd16777216;

  localparam logic [63:0] US_PER_S = 64'd1000000;

endpackage

// ===== rtl/core/kalman_ca_position_tracker.sv =====
// Top level of the 1-D constant-acceleration Kalman tracker.
// Sequencer, shared 64-bit multiplier and bit-serial divider; uses kcpt_pkg.
`timescale 1ns / 1ps

// One item at a time. Init and ignored opcodes go straight to the output
// state. Predict takes one division for dt and 83 fixed-point products
// through the single 32x32 multiplier (four partial products per 64-bit
// product). Predict with update adds a check state and, if the innovation
// variance is positive, the three gain divisions and 12 products. The input
// is ready only while the sequencer is idle; the result sits in an output
// register until it is taken.
module kalman_ca_position_tracker
  import kcpt_pkg::*;
#(
  parameter int INTERNAL_FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // time_us [31:0], observed_pos [63:32]
  input  logic [1:0]           s_tuser,   // opcode [1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // position [31:0], velocity [63:32]
  output logic [0:0]           m_tuser,   // update_applied [0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int FB = INTERNAL_FRAC_BITS;
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FB;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FB - 1);
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DT, ST_DT2A, ST_DT2B, ST_X, ST_FP, ST_PN, ST_GG, ST_GQ,
    ST_S, ST_KG, ST_UX, ST_UP, ST_OUT
  } state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] reg_fx(input logic [31:0] v);
    return $signed({32'd0, v} << (FB - 24));
  endfunction

  function automatic logic [31:0] to_q20(input logic signed [63:0] v);
    logic [63:0] m;
    m = (mag64(v) + (64'd1 << (FB - 21))) >> (FB - 20);
    if (v[63]) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
    return 4'({2'd0, r} * 4'd3 + {2'd0, c});
  endfunction

  function automatic logic signed [63:0] fm(input logic [1:0] r, input logic [1:0] c,
                                            input logic signed [63:0] d1,
                                            input logic signed [63:0] d2);
    if (r == c) return ONE;
    if ((r == 2'd0 && c == 2'd1) || (r == 2'd1 && c == 2'd2)) return d1;
    if (r == 2'd0 && c == 2'd2) return d2;
    return '0;
  endfunction

  function automatic logic signed [63:0] gv(input logic [1:0] r,
                                            input logic signed [63:0] d1,
                                            input logic signed [63:0] d2);
    case (r)
      2'd0:    return d2;
      2'd1:    return d1;
      default: return ONE;
    endcase
  endfunction

  // configuration
  logic [31:0] process_noise, measurement_noise;
  logic [19:0] fallback_dt_us;
  logic [31:0] init_var_position, init_var_velocity, init_var_accel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= RST_PROC_NOISE;
      measurement_noise <= RST_MEAS_NOISE;
      fallback_dt_us    <= RST_FALLBACK;
      init_var_position <= RST_VAR_POS;
      init_var_velocity <= RST_VAR_VEL;
      init_var_accel    <= RST_VAR_ACC;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROC_NOISE: process_noise     <= cfg_data;
        CFG_MEAS_NOISE: measurement_noise <= cfg_data;
        CFG_FALLBACK:   fallback_dt_us    <= cfg_data[19:0];
        CFG_VAR_POS:    init_var_position <= cfg_data;
        CFG_VAR_VEL:    init_var_velocity <= cfg_data;
        CFG_VAR_ACC:    init_var_accel    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t state;
  logic   issued;
  logic [1:0] ci, cj, ck;
  logic [1:0] op;
  logic signed [63:0] zq, dt, dt2, tmp, acc, resid, sreg;
  logic [31:0] dtus, last_time;
  logic signed [63:0] xs [3];
  logic signed [63:0] pc [9];
  logic signed [63:0] fp [9];
  logic signed [63:0] kg [3];

  // shared multiplier: four 32x32 partial products, then round and saturate
  logic               mstart, mbusy, mdone;
  logic signed [63:0] opa, opb, mres;
  logic [63:0]        mua, mub, pp;
  logic               mneg;
  logic [2:0]         mcnt;
  logic [1:0]         pshift;
  logic [127:0]       mprod, mrnd, pp_al;
  logic [63:0]        mmag;
  logic [31:0]        pa, pb;

  assign pa = mcnt[0] ? mua[63:32] : mua[31:0];
  assign pb = mcnt[1] ? mub[63:32] : mub[31:0];

  always_comb begin
    case (pshift)
      2'd0:    pp_al = {64'd0, pp};
      2'd1:    pp_al = {32'd0, pp, 32'd0};
      default: pp_al = {pp, 64'd0};
    endcase
    mrnd = mprod + (128'd1 << (FB - 1));
    mmag = (|(mrnd >> (FB + 64))) ? '1 : mrnd[FB +: 64];
    if (mmag[63]) mmag = 64'h7FFF_FFFF_FFFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (mstart) begin
        mua   <= mag64(opa);
        mub   <= mag64(opb);
        mneg  <= opa[63] ^ opb[63];
        mprod <= '0;
        mcnt  <= '0;
        mbusy <= 1'b1;
      end else if (mbusy) begin
        if (mcnt <= 3'd3) begin
          pp     <= pa * pb;
          pshift <= {1'b0, mcnt[0]} + {1'b0, mcnt[1]};
        end
        if (mcnt >= 3'd1 && mcnt <= 3'd4) mprod <= mprod + pp_al;
        if (mcnt == 3'd5) begin
          mres  <= mneg ? $signed(-mmag) : $signed(mmag);
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
        mcnt <= mcnt + 3'd1;
      end
    end
  end

  // shared divider: restoring, one quotient bit per cycle, round half away from zero
  logic               dstart, dbusy, ddone;
  logic signed [63:0] div_num, dres;
  logic [63:0]        div_den, drem, dquo, ddvs, dq_fin, r2;
  logic [127:0]       dsh;
  logic               dneg, dovf, dov_fin;
  logic [7:0]         dcnt;

  assign r2 = {drem[62:0], dsh[127]};

  always_comb begin
    dov_fin = dovf;
    dq_fin  = dquo;
    if (drem >= ddvs - drem) begin
      if (&dquo) dov_fin = 1'b1;
      else dq_fin = dquo + 64'd1;
    end
    if (dov_fin) dq_fin = '1;
    if (dq_fin[63]) dq_fin = 64'h7FFF_FFFF_FFFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (dstart) begin
        dneg  <= div_num[63];
        dsh   <= {64'd0, mag64(div_num)} << FB;
        ddvs  <= div_den;
        drem  <= '0;
        dquo  <= '0;
        dovf  <= 1'b0;
        dcnt  <= '0;
        dbusy <= 1'b1;
      end else if (dbusy) begin
        if (!dcnt[7]) begin
          dsh  <= dsh << 1;
          dovf <= dovf | dquo[63];
          if (r2 >= ddvs) begin
            drem <= r2 - ddvs;
            dquo <= {dquo[62:0], 1'b1};
          end else begin
            drem <= r2;
            dquo <= {dquo[62:0], 1'b0};
          end
          dcnt <= dcnt + 8'd1;
        end else begin
          dres  <= dneg ? $signed(-dq_fin) : $signed(dq_fin);
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  // operand selection
  logic is_mul, is_div;
  always_comb begin
    opa     = '0;
    opb     = '0;
    div_num = $signed(64'(dtus));
    div_den = US_PER_S;
    is_mul  = 1'b1;
    is_div  = 1'b0;
    case (state)
      ST_DT2A: begin opa = dt;               opb = dt; end
      ST_DT2B: begin opa = tmp;              opb = HALF; end
      ST_X:    begin opa = fm(ci, ck, dt, dt2); opb = xs[ck]; end
      ST_FP:   begin opa = fm(ci, ck, dt, dt2); opb = pc[idx(ck, cj)]; end
      ST_PN:   begin opa = fp[idx(ci, ck)];  opb = fm(cj, ck, dt, dt2); end
      ST_GG:   begin opa = gv(ci, dt, dt2);  opb = gv(cj, dt, dt2); end
      ST_GQ:   begin opa = tmp;              opb = reg_fx(process_noise); end
      ST_UX:   begin opa = kg[ci];           opb = resid; end
      ST_UP:   begin opa = kg[ci];           opb = pc[idx(2'd0, cj)]; end
      ST_DT:   begin is_mul = 1'b0; is_div = 1'b1; end
      ST_KG: begin
        is_mul  = 1'b0;
        is_div  = 1'b1;
        div_num = pc[idx(ci, 2'd0)];
        div_den = sreg;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mstart = is_mul && !issued;
  assign dstart = is_div && !issued;

  logic signed [63:0] msum, s_inn;
  logic [31:0]        dlt;
  assign msum  = sadd(acc, mres);
  assign s_inn = sadd(pc[0], reg_fx(measurement_noise));
  assign dlt   = s_tdata[31:0] - last_time;

  logic upd;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      m_tvalid  <= 1'b0;
      last_time <= '0;
      for (int n = 0; n < 3; n++) xs[n] <= '0;
      for (int n = 0; n < 9; n++) pc[n] <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      if (is_mul || is_div) begin
        if (!issued) issued <= 1'b1;
        else if (mdone || ddone) issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op  <= s_tuser;
            zq  <= $signed({{32{s_tdata[63]}}, s_tdata[63:32]}) <<< (FB - 20);
            upd <= 1'b0;
            ci  <= '0;
            cj  <= '0;
            ck  <= '0;
            acc <= '0;
            case (s_tuser)
              OP_INIT: begin
                xs[0] <= $signed({{32{s_tdata[63]}}, s_tdata[63:32]}) <<< (FB - 20);
                xs[1] <= '0;
                xs[2] <= '0;
                for (int n = 0; n < 9; n++) begin
                  if (n != 0 && n != 4 && n != 8) pc[n] <= '0;
                end
                pc[0] <= reg_fx(init_var_position);
                pc[4] <= reg_fx(init_var_velocity);
                pc[8] <= reg_fx(init_var_accel);
                last_time <= s_tdata[31:0];
                state <= ST_OUT;
              end
              OP_PREDICT, OP_UPDATE: begin
                dtus <= (dlt == 32'd0 || dlt[31]) ? {12'd0, fallback_dt_us} : dlt;
                last_time <= s_tdata[31:0];
                state <= ST_DT;
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_DT: if (ddone) begin
          dt    <= dres;
          state <= ST_DT2A;
        end
        ST_DT2A: if (mdone) begin
          tmp   <= mres;
          state <= ST_DT2B;
        end
        ST_DT2B: if (mdone) begin
          dt2   <= mres;
          state <= ST_X;
        end
        ST_X: if (mdone) begin
          if (ck == 2'd2) begin
            xs[ci] <= msum;
            acc    <= '0;
            ck     <= '0;
            if (ci == 2'd2) begin
              ci    <= '0;
              state <= ST_FP;
            end else ci <= ci + 2'd1;
          end else begin
            acc <= msum;
            ck  <= ck + 2'd1;
          end
        end
        ST_FP: if (mdone) begin
          if (ck == 2'd2) begin
            fp[idx(ci, cj)] <= msum;
            acc <= '0;
            ck  <= '0;
            if (cj == 2'd2) begin
              cj <= '0;
              if (ci == 2'd2) begin
                ci    <= '0;
                state <= ST_PN;
              end else ci <= ci + 2'd1;
            end else cj <= cj + 2'd1;
          end else begin
            acc <= msum;
            ck  <= ck + 2'd1;
          end
        end
        ST_PN: if (mdone) begin
          acc <= msum;
          if (ck == 2'd2) begin
            ck    <= '0;
            state <= ST_GG;
          end else ck <= ck + 2'd1;
        end
        ST_GG: if (mdone) begin
          tmp   <= mres;
          state <= ST_GQ;
        end
        ST_GQ: if (mdone) begin
          pc[idx(ci, cj)] <= msum;
          acc   <= '0;
          if (cj == 2'd2) begin
            cj <= '0;
            if (ci == 2'd2) begin
              ci    <= '0;
              state <= (op == OP_UPDATE) ? ST_S : ST_OUT;
            end else begin
              ci    <= ci + 2'd1;
              state <= ST_PN;
            end
          end else begin
            cj    <= cj + 2'd1;
            state <= ST_PN;
          end
        end
        ST_S: begin
          if (s_inn[63] || s_inn == '0) state <= ST_OUT;
          else begin
            sreg  <= s_inn;
            resid <= ssub(zq, xs[0]);
            ci    <= '0;
            state <= ST_KG;
          end
        end
        ST_KG: if (ddone) begin
          kg[ci] <= dres;
          if (ci == 2'd2) begin
            ci    <= '0;
            state <= ST_UX;
          end else ci <= ci + 2'd1;
        end
        ST_UX: if (mdone) begin
          xs[ci] <= sadd(xs[ci], mres);
          if (ci == 2'd2) begin
            cj    <= '0;
            state <= ST_UP;
          end else ci <= ci + 2'd1;
        end
        ST_UP: if (mdone) begin
          pc[idx(ci, cj)] <= ssub(pc[idx(ci, cj)], mres);
          if (cj == 2'd2) begin
            cj <= '0;
            if (ci == 2'd0) begin
              upd   <= 1'b1;
              state <= ST_OUT;
            end else ci <= ci - 2'd1;
          end else cj <= cj + 2'd1;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {to_q20(xs[1]), to_q20(xs[0])};
            m_tuser  <= upd;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/kcpt_checker.sv =====
// Port-level checks for the position tracker, bound to the top level.
// Uses kcpt_pkg for the opcode codes.
`timescale 1ns / 1ps

module kcpt_checker
  import kcpt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [0:0] m_tuser
);

  logic [1:0] op_head, op_next;
  logic [1:0] n_pend;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // opcodes of accepted items whose results are not yet taken, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      n_pend  <= '0;
      op_head <= OP_INIT;
      op_next <= OP_INIT;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10: begin
          if (n_pend == 2'd0) op_head <= s_tuser;
          else op_next <= s_tuser;
          n_pend <= n_pend + 2'd1;
        end
        2'b01: begin
          op_head <= op_next;
          n_pend  <= n_pend - 2'd1;
        end
        2'b11: begin
          if (n_pend == 2'd1) op_head <= s_tuser;
          else begin
            op_head <= op_next;
            op_next <= s_tuser;
          end
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  a_update_op: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> n_pend != 2'd0 && op_head == OP_UPDATE)
    else $error("update flagged for an item without a measurement");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind kalman_ca_position_tracker kcpt_checker u_kcpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser)
);
